// File: rtl/rrdc_pkg.sv
// Package for the RNDIS receive deframer and classifier.
// Holds item types, command type, verdict codes and protocol constants.
// No dependencies.
package rrdc_pkg;

    localparam int DEF_MAX_TRANSFER = 2048;
    localparam int DEF_CMD_DEPTH    = 4;

    localparam int LIMIT_W = 12;
    localparam int FLEN_W  = 12;
    localparam int VERD_W  = 3;

    localparam logic [VERD_W-1:0] VERD_NOT_RNDIS = 3'd0;
    localparam logic [VERD_W-1:0] VERD_TOO_SHORT = 3'd1;
    localparam logic [VERD_W-1:0] VERD_BAD_LEN   = 3'd2;
    localparam logic [VERD_W-1:0] VERD_ETH_SHORT = 3'd3;
    localparam logic [VERD_W-1:0] VERD_ARP       = 3'd4;
    localparam logic [VERD_W-1:0] VERD_ICMP      = 3'd5;
    localparam logic [VERD_W-1:0] VERD_OTHER     = 3'd6;

    localparam logic [0:0] KIND_PAYLOAD = 1'b0;
    localparam logic [0:0] KIND_VERDICT = 1'b1;

    localparam logic [31:0] RNDIS_PACKET_MSG = 32'd2;
    localparam logic [15:0] ETH_TYPE_ARP     = 16'h0806;
    localparam logic [15:0] ETH_TYPE_IPV4    = 16'h0800;
    localparam logic [7:0]  IP_PROTO_ICMP    = 8'd1;
    localparam int          MIN_TRANSFER_LEN = 44;
    localparam int          MIN_ETH_LEN      = 14;
    localparam int          RNDIS_HDR_LEN    = 16;
    localparam int          DATA_OFFSET_BIAS = 8;
    localparam int          ETH_TYPE_HI_POS  = 12;
    localparam int          ETH_TYPE_LO_POS  = 13;
    localparam int          IP_PROTO_POS     = 23;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_transfer;
    } t_in_item;

    typedef struct packed {
        logic              result_kind;
        logic [7:0]        payload_byte;
        logic [VERD_W-1:0] verdict;
        logic [FLEN_W-1:0] frame_length;
        logic              run_end;
    } t_out_item;

    // One accepted byte's worth of work for the back end.
    typedef struct packed {
        logic              has_payload;
        logic [7:0]        payload_byte;
        logic              has_verdict;
        logic [VERD_W-1:0] verdict;
        logic [FLEN_W-1:0] frame_length;
    } t_cmd;

endpackage

// File: rtl/rrdc_front.sv
// Front end: parses the RNDIS header, tracks the data window and classifies.
// Produces one command per accepted byte that causes results.
// Depends on rrdc_pkg.
module rrdc_front #(
    parameter int MAX_TRANSFER = rrdc_pkg::DEF_MAX_TRANSFER
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [rrdc_pkg::LIMIT_W-1:0]        i_transfer_limit,
    input  logic                                i_accept,
    input  rrdc_pkg::t_in_item                  i_item,
    output logic                                o_push,
    output rrdc_pkg::t_cmd                      o_cmd
);
    import rrdc_pkg::*;

    localparam int POS_W = $clog2(MAX_TRANSFER + 1);
    localparam int LIM_W = (POS_W > LIMIT_W) ? POS_W : LIMIT_W;

    function automatic logic [31:0] put_le(input logic [31:0] word, input logic [1:0] lane,
                                           input logic [7:0] b);
        logic [31:0] w;
        w = word;
        w[8*lane +: 8] = b;
        return w;
    endfunction

    logic [POS_W-1:0] r_pos,   n_pos;
    logic [31:0]      r_msg,   n_msg;
    logic [31:0]      r_off,   n_off;
    logic [31:0]      r_len,   n_len;
    logic [32:0]      r_start, n_start;
    logic [33:0]      r_stop,  n_stop;
    logic [15:0]      r_ether, n_ether;
    logic [7:0]       r_proto, n_proto;
    logic             r_ovf,   n_ovf;

    logic [LIM_W-1:0] w_limit;
    logic [LIM_W-1:0] w_tl_ext;
    logic             w_drop;
    logic             w_stream;
    logic [POS_W-1:0] w_rel;
    logic [VERD_W-1:0] w_verdict;
    logic [FLEN_W-1:0] w_flen;

    assign w_tl_ext = LIM_W'(i_transfer_limit);
    assign w_limit  = (w_tl_ext < LIM_W'(MAX_TRANSFER)) ? w_tl_ext : LIM_W'(MAX_TRANSFER);
    assign w_drop   = LIM_W'(r_pos) >= w_limit;
    assign w_rel    = r_pos - r_start[POS_W-1:0];

    assign w_stream = !w_drop && (r_pos >= POS_W'(RNDIS_HDR_LEN))
                   && (r_msg == RNDIS_PACKET_MSG)
                   && (r_start >= 33'(RNDIS_HDR_LEN))
                   && (33'(r_pos) >= r_start)
                   && (34'(r_pos) < r_stop);

    // Header capture, window capture and position advance.
    always_comb begin
        n_pos   = r_pos;
        n_msg   = r_msg;
        n_off   = r_off;
        n_len   = r_len;
        n_start = r_start;
        n_stop  = r_stop;
        n_ether = r_ether;
        n_proto = r_proto;
        n_ovf   = r_ovf;
        if (w_drop) begin
            n_ovf = 1'b1;
        end else begin
            if (r_pos < POS_W'(4)) begin
                n_msg = put_le(r_msg, r_pos[1:0], i_item.rx_byte);
            end else if (r_pos[POS_W-1:2] == (POS_W-2)'(2)) begin
                n_off   = put_le(r_off, r_pos[1:0], i_item.rx_byte);
                n_start = 33'(n_off) + 33'(DATA_OFFSET_BIAS);
            end else if (r_pos[POS_W-1:2] == (POS_W-2)'(3)) begin
                n_len  = put_le(r_len, r_pos[1:0], i_item.rx_byte);
                n_stop = 34'(r_start) + 34'(n_len);
            end else if (w_stream) begin
                if (w_rel == POS_W'(ETH_TYPE_HI_POS)) begin
                    n_ether[15:8] = i_item.rx_byte;
                end else if (w_rel == POS_W'(ETH_TYPE_LO_POS)) begin
                    n_ether[7:0] = i_item.rx_byte;
                end else if (w_rel == POS_W'(IP_PROTO_POS)) begin
                    n_proto = i_item.rx_byte;
                end
            end
            n_pos = r_pos + POS_W'(1);
        end
    end

    // Header words are settled by the time the position passes the too-short
    // bound, so the registered copies serve the verdict.
    always_comb begin
        w_flen = (r_len > 32'(2**FLEN_W - 1)) ? FLEN_W'(2**FLEN_W - 1) : r_len[FLEN_W-1:0];
        if (n_pos <= POS_W'(MIN_TRANSFER_LEN)) begin
            w_verdict = VERD_TOO_SHORT;
            w_flen    = '0;
        end else if (r_msg != RNDIS_PACKET_MSG) begin
            w_verdict = VERD_NOT_RNDIS;
            w_flen    = '0;
        end else if (n_ovf) begin
            w_verdict = VERD_BAD_LEN;
        end else if ((r_len == 32'd0) || (r_start < 33'(RNDIS_HDR_LEN))
                     || (r_stop > 34'(n_pos))) begin
            w_verdict = VERD_BAD_LEN;
        end else if (r_len < 32'(MIN_ETH_LEN)) begin
            w_verdict = VERD_ETH_SHORT;
        end else if (n_ether == ETH_TYPE_ARP) begin
            w_verdict = VERD_ARP;
        end else if ((n_ether == ETH_TYPE_IPV4) && (n_proto == IP_PROTO_ICMP)) begin
            w_verdict = VERD_ICMP;
        end else begin
            w_verdict = VERD_OTHER;
        end
    end

    assign o_push = i_accept && (w_stream || i_item.end_of_transfer);

    always_comb begin
        o_cmd.has_payload  = w_stream;
        o_cmd.payload_byte = i_item.rx_byte;
        o_cmd.has_verdict  = i_item.end_of_transfer;
        o_cmd.verdict      = w_verdict;
        o_cmd.frame_length = w_flen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_msg   <= '0;
            r_off   <= '0;
            r_len   <= '0;
            r_start <= 33'(DATA_OFFSET_BIAS);
            r_stop  <= 34'(DATA_OFFSET_BIAS);
            r_ether <= '0;
            r_proto <= '0;
            r_ovf   <= 1'b0;
        end else if (i_accept) begin
            if (i_item.end_of_transfer) begin
                // clear the transfer after its verdict
                r_pos   <= '0;
                r_msg   <= '0;
                r_off   <= '0;
                r_len   <= '0;
                r_start <= 33'(DATA_OFFSET_BIAS);
                r_stop  <= 34'(DATA_OFFSET_BIAS);
                r_ether <= '0;
                r_proto <= '0;
                r_ovf   <= 1'b0;
            end else begin
                r_pos   <= n_pos;
                r_msg   <= n_msg;
                r_off   <= n_off;
                r_len   <= n_len;
                r_start <= n_start;
                r_stop  <= n_stop;
                r_ether <= n_ether;
                r_proto <= n_proto;
                r_ovf   <= n_ovf;
            end
        end
    end

endmodule

// File: rtl/rrdc_cmd_queue.sv
// Short command queue between the front end and the back end.
// Register-based ring buffer with a fill count. Depends on rrdc_pkg.
module rrdc_cmd_queue #(
    parameter int DEPTH = rrdc_pkg::DEF_CMD_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  rrdc_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_head_valid,
    output rrdc_pkg::t_cmd  o_head
);
    import rrdc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count;
    logic             w_pop;

    assign o_full       = r_count == CNT_W'(DEPTH);
    assign o_head_valid = r_count != '0;
    assign o_head       = r_mem[r_rd];
    assign w_pop        = i_pop && o_head_valid;

    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (w_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && w_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// File: rtl/rrdc_back.sv
// Back end: expands queued commands into result items in an output register.
// A command with both a payload byte and a verdict yields two result items, payload byte first.
// Depends on rrdc_pkg.
module rrdc_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_head_valid,
    input  rrdc_pkg::t_cmd       i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output rrdc_pkg::t_out_item  o_item
);
    import rrdc_pkg::*;

    logic      r_valid;
    logic      r_second, n_second;
    t_out_item r_item,   n_item;
    logic      w_load;

    assign w_load = !r_valid || i_ready;

    always_comb begin
        n_second = r_second;
        o_pop    = 1'b0;
        n_item   = '0;
        if (w_load && i_head_valid) begin
            if (i_head.has_payload && !r_second) begin
                n_item.result_kind  = KIND_PAYLOAD;
                n_item.payload_byte = i_head.payload_byte;
                n_item.run_end      = !i_head.has_verdict;
                if (i_head.has_verdict) begin
                    n_second = 1'b1;
                end else begin
                    o_pop = 1'b1;
                end
            end else begin
                n_item.result_kind  = KIND_VERDICT;
                n_item.verdict      = i_head.verdict;
                n_item.frame_length = i_head.frame_length;
                n_item.run_end      = 1'b1;
                n_second            = 1'b0;
                o_pop               = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_second <= n_second;
            if (w_load) begin
                r_valid <= i_head_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_head_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/rndis_rx_deframer_classifier_core.sv
// RNDIS receive deframer and classifier, top level.
// Instantiates front end, command queue and back end. Depends on rrdc_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in): one byte of a received
//   bulk transfer per item, end_of_transfer set on the final byte.
//   Output channel (o_out_valid / i_out_ready / o_out): payload byte items for
//   the Ethernet frame inside the RNDIS data window, then one verdict item per
//   transfer carrying the class and the header data length.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data): writes the
//   transfer limit; always ready. Write it only while the block is idle.
// Timing:
//   A byte is parsed and classified in the cycle it is accepted; its command
//   is registered in the queue, and from there its result is loaded into the
//   output register. The block takes one byte per cycle while the queue has
//   room. The final byte of a transfer that also carries frame data yields
//   two results; the command queue (CMD_DEPTH entries) soaks that up.
// Reset: synchronous, active low; clears all transfer state, empties the
//   queue and sets the transfer limit to 1536.
// Stall: when the receiver holds i_out_ready low the output item holds, the
//   queue fills, and o_in_ready drops once the queue is full.
module rndis_rx_deframer_classifier_core #(
    parameter int MAX_TRANSFER = rrdc_pkg::DEF_MAX_TRANSFER,
    parameter int CMD_DEPTH    = rrdc_pkg::DEF_CMD_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [rrdc_pkg::LIMIT_W-1:0]  i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  rrdc_pkg::t_in_item            i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rrdc_pkg::t_out_item           o_out
);
    import rrdc_pkg::*;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1536);

    logic [LIMIT_W-1:0] r_transfer_limit;
    logic               w_accept;
    logic               w_push;
    t_cmd               w_cmd;
    logic               w_full;
    logic               w_head_valid;
    t_cmd               w_head;
    logic               w_pop;

    // Config register: always take writes.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_transfer_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            r_transfer_limit <= i_cfg_data;
        end
    end

    // Accept a byte whenever the queue has room for its command.
    assign o_in_ready = !w_full;
    assign w_accept   = i_in_valid && o_in_ready;

    rrdc_front #(
        .MAX_TRANSFER (MAX_TRANSFER)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_transfer_limit (r_transfer_limit),
        .i_accept         (w_accept),
        .i_item           (i_in),
        .o_push           (w_push),
        .o_cmd            (w_cmd)
    );

    rrdc_cmd_queue #(
        .DEPTH (CMD_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_cmd        (w_cmd),
        .i_pop        (w_pop),
        .o_full       (w_full),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    rrdc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_out_valid),
        .i_ready      (i_out_ready),
        .o_item       (o_out)
    );

    // A verdict always closes the results of its byte.
    a_verdict_ends_run : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.result_kind == KIND_VERDICT) |-> o_out.run_end)
        else $error("verdict item without run_end");

    // A payload byte that does not end its run is followed at once by the verdict.
    a_payload_then_verdict : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && (o_out.result_kind == KIND_PAYLOAD) && !o_out.run_end
        |=> o_out_valid && (o_out.result_kind == KIND_VERDICT))
        else $error("verdict missing after last payload byte");

    // Not-RNDIS and too-short verdicts carry no frame length.
    a_no_length_on_reject : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.result_kind == KIND_VERDICT)
        && ((o_out.verdict == VERD_NOT_RNDIS) || (o_out.verdict == VERD_TOO_SHORT))
        |-> o_out.frame_length == '0)
        else $error("frame length on rejected transfer");

endmodule
